// ----- src/rcs_pkg.sv -----
// Shared types, constants and tables for the rgb contrast stretch block.
// No dependencies; every other file of the block imports this package.
package rcs_pkg;

  localparam int Channels  = 3;
  localparam int PixW      = 8;
  localparam int CfgIdxW   = 4;
  localparam int OpW       = 11;
  localparam int NumW      = 20;
  localparam int DenW      = 9;
  localparam int DivSteps  = 8;
  // three front stages, overflow stage, one stage per quotient bit, output register
  localparam int PipeDepth = 3 + 1 + DivSteps + 1;

  typedef enum logic [1:0] {
    ModeLinear = 2'd0,
    ModePiece  = 2'd1,
    ModeLog    = 2'd2,
    ModeExp    = 2'd3
  } mode_e;

  localparam logic [CfgIdxW-1:0] CfgMode      = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgSegs      = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgRedLow    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgRedHigh   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgGreenLow  = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgGreenHigh = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgBlueLow   = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgBlueHigh  = 4'd7;

  typedef struct packed {
    logic [PixW-1:0] red_in;
    logic [PixW-1:0] green_in;
    logic [PixW-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] red_out;
    logic [PixW-1:0] green_out;
    logic [PixW-1:0] blue_out;
  } pix_out_t;

  // sideband that travels beside the divider
  typedef struct packed {
    logic            zero;
    logic            use_lut;
    logic [PixW-1:0] lut_val;
    logic [PixW-1:0] base;
  } side_t;

  typedef logic [PixW-1:0] lut_t [256];

  // segment slopes and bases, row = segment count - 3
  localparam logic [7:0] SegSlope [3][5] = '{
    '{8'd63, 8'd128, 8'd64, 8'd0, 8'd0},
    '{8'd31, 8'd96, 8'd96, 8'd32, 8'd0},
    '{8'd15, 8'd64, 8'd96, 8'd64, 8'd16}};
  localparam logic [7:0] SegBase [3][5] = '{
    '{8'd0, 8'd63, 8'd191, 8'd0, 8'd0},
    '{8'd0, 8'd31, 8'd127, 8'd191, 8'd0},
    '{8'd0, 8'd15, 8'd79, 8'd175, 8'd239}};

  // long division by shift and subtract, used only by the log table builder
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // 46*ln(p+1), ln accumulated in Q56 from atanh series terms
  function automatic lut_t build_log_lut();
    lut_t        t;
    logic [63:0] ln;
    logic [63:0] m;
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] i;
    logic [63:0] v;
    ln   = '0;
    t[0] = '0;
    for (int n = 2; n <= 256; n++) begin
      m   = 64'(2 * n - 1);
      pw  = udiv64(64'd1 << 56, m);
      sum = '0;
      i   = 64'd1;
      while (pw != 0) begin
        sum = sum + udiv64(pw, i);
        pw  = udiv64(pw, m * m);
        i   = i + 64'd2;
      end
      ln = ln + 2 * sum;
      v  = ((ln >> 24) * 64'd46 + (64'd1 << 31)) >> 32;
      t[n-1] = (v > 64'd255) ? 8'd255 : v[7:0];
    end
    return t;
  endfunction

  function automatic logic [63:0] mul_q40(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    return pr[103:40];
  endfunction

  // 2.72^(0.02173*p) by square and multiply in Q40
  function automatic lut_t build_exp_lut();
    lut_t        t;
    logic [63:0] acc;
    logic [63:0] bs;
    logic [63:0] v;
    for (int p = 0; p < 256; p++) begin
      acc = 64'd1 << 40;
      bs  = 64'd4389378616 << 8;
      for (int b = 0; b < 8; b++) begin
        if (((p >> b) & 1) != 0) acc = mul_q40(acc, bs);
        bs = mul_q40(bs, bs);
      end
      v = (acc + (64'd1 << 39)) >> 40;
      t[p] = (v > 64'd255) ? 8'd255 : v[7:0];
    end
    return t;
  endfunction

  localparam lut_t LogLut = build_log_lut();
  localparam lut_t ExpLut = build_exp_lut();

endpackage

// ----- src/rcs_prep.sv -----
// Front three stages of one channel: bounds, segment choice, numerator product.
// Depends on rcs_pkg.
module rcs_prep (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rcs_pkg::PixW-1:0]    pix_i,
  input  logic [rcs_pkg::PixW-1:0]    low_i,
  input  logic [rcs_pkg::PixW-1:0]    high_i,
  input  rcs_pkg::mode_e              mode_i,
  input  logic [2:0]                  segs_i,
  output logic [rcs_pkg::NumW-1:0]    num_o,
  output logic [rcs_pkg::DenW:0]      den2_o,
  output rcs_pkg::side_t              side_o
);
  import rcs_pkg::*;

  // stage a signals
  logic [2:0]      s_d, s_q;
  logic [PixW-1:0] dd_d, dd_q;
  logic [DenW-1:0] r_d, r_q;
  logic [PixW-1:0] dl_d, dl_q;
  logic [OpW-1:0]  sd1_d, sd1_q;
  logic            lz_d, lz_q, pz_d, pz_q;
  logic [PixW-1:0] lv_d, lv_q;
  mode_e           md_q;

  // stage b signals
  logic [OpW-1:0]  op_d, op_q;
  logic [7:0]      sl_d, sl_q;
  logic [DenW-1:0] dn_d, dn_q;
  side_t           sb_d, sb_q;

  // stage c signals
  logic [NumW-1:0] num_q;
  logic [DenW:0]   den2_q;
  side_t           sc_q;

  // stage a: offsets, range and flags
  always_comb begin
    unique case (segs_i)
      3'd3:    s_d = 3'd3;
      3'd4:    s_d = 3'd4;
      default: s_d = 3'd5;
    endcase
    dd_d  = pix_i - low_i;
    r_d   = {1'b0, high_i} - {1'b0, low_i} + 9'd1;
    dl_d  = high_i - low_i;
    sd1_d = OpW'(({1'b0, dd_d} + 9'd1) * s_d);
    lz_d  = (high_i <= low_i) || (pix_i <= low_i);
    pz_d  = (high_i <= low_i) || (pix_i < low_i);
    lv_d  = (mode_i == ModeLog) ? LogLut[pix_i] : ExpLut[pix_i];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d; dd_q <= dd_d; r_q <= r_d; dl_q <= dl_d; sd1_q <= sd1_d;
      lz_q <= lz_d; pz_q <= pz_d; lv_q <= lv_d; md_q <= mode_i;
    end
  end

  // stage b: segment search and operand selection
  always_comb begin
    logic [2:0]     j;
    logic [1:0]     row;
    logic [OpW-1:0] jr;
    j   = s_q;
    row = 2'(s_q - 3'd3);
    for (int k = 4; k >= 1; k--) begin
      if (3'(k) < s_q && sd1_q <= OpW'(r_q * 3'(k))) j = 3'(k);
    end
    jr = OpW'(r_q * 3'(j - 3'd1));
    sb_d.lut_val = lv_q;
    sb_d.use_lut = (md_q == ModeLog) || (md_q == ModeExp);
    if (md_q == ModeLinear) begin
      op_d = OpW'(dd_q);
      sl_d = 8'd255;
      dn_d = {1'b0, dl_q};
      sb_d.base = '0;
      sb_d.zero = lz_q;
    end else if (j == 3'd1) begin
      op_d = OpW'(dd_q * s_q);
      sl_d = SegSlope[row][0];
      dn_d = r_q - {6'd0, s_q};
      sb_d.base = '0;
      sb_d.zero = (md_q == ModePiece) && (pz_q || dd_q == '0);
    end else begin
      op_d = sd1_q - jr;
      sl_d = SegSlope[row][j-3'd1];
      dn_d = r_q;
      sb_d.base = SegBase[row][j-3'd1];
      sb_d.zero = (md_q == ModePiece) && pz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d; sl_q <= sl_d; dn_q <= dn_d; sb_q <= sb_d;
    end
  end

  // stage c: numerator product, doubled for round to nearest
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {NumW'(op_q * sl_q) << 1} + NumW'(dn_q);
      den2_q <= {dn_q, 1'b0};
      sc_q   <= sb_q;
    end
  end

  assign num_o  = num_q;
  assign den2_o = den2_q;
  assign side_o = sc_q;

endmodule

// ----- src/rcs_div.sv -----
// Pipelined restoring divider with saturation, one quotient bit per stage,
// and the final result select. Depends on rcs_pkg.
module rcs_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rcs_pkg::NumW-1:0]    num_i,
  input  logic [rcs_pkg::DenW:0]      den2_i,
  input  rcs_pkg::side_t              side_i,
  output logic [rcs_pkg::PixW-1:0]    res_o
);
  import rcs_pkg::*;

  logic [NumW-1:0]     rem_q  [DivSteps+1];
  logic [DivSteps-1:0] quo_q  [DivSteps+1];
  logic [DenW:0]       den_q  [DivSteps+1];
  logic                ovf_q  [DivSteps+1];
  side_t               side_q [DivSteps+1];
  logic [PixW:0]       sum;

  // overflow stage: quotient of 256 or more saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      quo_q[0]  <= '0;
      den_q[0]  <= den2_i;
      ovf_q[0]  <= num_i >= (NumW'(den2_i) << DivSteps);
      side_q[0] <= side_i;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [NumW-1:0] sh;
    assign sh = NumW'(den_q[k-1]) << (DivSteps - k);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[k-1] >= sh) begin
          rem_q[k] <= rem_q[k-1] - sh;
          quo_q[k] <= quo_q[k-1] | (DivSteps'(1) << (DivSteps - k));
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
        den_q[k]  <= den_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // add segment base, saturate, pick table value or zero
  always_comb begin
    sum = {1'b0, side_q[DivSteps].base} + {1'b0, quo_q[DivSteps]};
    if (side_q[DivSteps].zero) begin
      res_o = '0;
    end else if (side_q[DivSteps].use_lut) begin
      res_o = side_q[DivSteps].lut_val;
    end else if (ovf_q[DivSteps] || sum[PixW]) begin
      res_o = '1;
    end else begin
      res_o = sum[PixW-1:0];
    end
  end

endmodule

// ----- src/rgb_contrast_stretch_unit.sv -----
// Top level of the rgb contrast stretch block: registers, channel lanes,
// valid line and output register. Depends on rcs_pkg, rcs_prep, rcs_div.
//
// Usage: pixels enter on in_valid_i/in_data_i and are taken at an edge where
// in_stall_o is low. Stretched pixels leave on out_valid_o/out_data_o and are
// taken at an edge where out_stall_i is low. Each colour channel runs in its
// own lane with its own low/high bounds.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i writes one register;
// cfg_ready_o is always high. Write only while no pixel is in flight.
// Pipeline: from acceptance to out_valid_o a pixel passes three front
// stages, a nine-stage divider (overflow check plus one quotient bit per
// stage) and the output register. Throughput: one pixel per cycle unless held.
// Reset: clears the valid line and loads mode linear, three segments and
// bounds 0..255 for every channel.
// Stall: while a result waits under out_stall_i the whole pipeline holds and
// in_stall_o is high; while no result waits the pipeline advances even under
// out_stall_i, but bubbles inside the pipeline are not removed.
module rgb_contrast_stretch_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rcs_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rcs_pkg::pix_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcs_pkg::PixW-1:0]      cfg_data_i
);
  import rcs_pkg::*;

  mode_e             mode_q;
  logic [2:0]        segs_q;
  logic [PixW-1:0]   low_q  [Channels];
  logic [PixW-1:0]   high_q [Channels];
  logic [PipeDepth-1:0] vld_q;
  logic              en;
  logic [PixW-1:0]   pix    [Channels];
  logic [PixW-1:0]   res    [Channels];
  logic [PixW-1:0]   out_q  [Channels];

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeLinear;
      segs_q <= 3'd3;
      for (int c = 0; c < Channels; c++) begin
        low_q[c]  <= '0;
        high_q[c] <= '1;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMode:      mode_q    <= mode_e'(cfg_data_i[1:0]);
        CfgSegs:      segs_q    <= cfg_data_i[2:0];
        CfgRedLow:    low_q[0]  <= cfg_data_i;
        CfgRedHigh:   high_q[0] <= cfg_data_i;
        CfgGreenLow:  low_q[1]  <= cfg_data_i;
        CfgGreenHigh: high_q[1] <= cfg_data_i;
        CfgBlueLow:   low_q[2]  <= cfg_data_i;
        CfgBlueHigh:  high_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: hold only while a finished result is stalled
  assign en         = !(vld_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  assign pix[0] = in_data_i.red_in;
  assign pix[1] = in_data_i.green_in;
  assign pix[2] = in_data_i.blue_in;

  // one lane per colour channel
  for (genvar c = 0; c < Channels; c++) begin : g_lane
    logic [NumW-1:0] num;
    logic [DenW:0]   den2;
    side_t           side;

    rcs_prep u_prep (
      .clk_i  (clk_i),
      .en_i   (en),
      .pix_i  (pix[c]),
      .low_i  (low_q[c]),
      .high_i (high_q[c]),
      .mode_i (mode_q),
      .segs_i (segs_q),
      .num_o  (num),
      .den2_o (den2),
      .side_o (side)
    );

    rcs_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num),
      .den2_i (den2),
      .side_i (side),
      .res_o  (res[c])
    );

    // output register
    always_ff @(posedge clk_i) begin
      if (en) out_q[c] <= res[c];
    end
  end

  assign out_valid_o          = vld_q[PipeDepth-1];
  assign out_data_o.red_out   = out_q[0];
  assign out_data_o.green_out = out_q[1];
  assign out_data_o.blue_out  = out_q[2];

endmodule

// ----- src/rcs_checker.sv -----
// Port-level checks for the rgb contrast stretch block, bound to the top.
// Depends on rcs_pkg and rgb_contrast_stretch_unit.
module rcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rcs_pkg::pix_out_t   out_data_o,
  input logic                cfg_ready_o
);
  import rcs_pkg::*;

  // a stalled result stays and keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input side is held exactly when a result is stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall mismatch");

  // an accepted pixel with no output stall after it appears after the latency
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 (!out_stall_i) [* (PipeDepth-1)] |=> out_valid_o)
    else $error("latency check failed");

  // the register port never pushes back
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind rgb_contrast_stretch_unit rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

// ----- tb/tb_rgb_contrast_stretch_unit.sv -----
// Self-checking testbench for rgb_contrast_stretch_unit: a directed table, then random
// pixels under random config settings, checked against an in-bench predictor.
// Depends on rcs_pkg and the rgb_contrast_stretch_unit RTL.
module tb_rgb_contrast_stretch_unit;
  import rcs_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 4'd12;
  localparam int Phases   = 9;
  localparam int PerPhase = 150;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pix_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pix_out_t          out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [PixW-1:0]   cfg_data_i = '0;

  rgb_contrast_stretch_unit uut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the block's registers
  mode_e      cur_mode;
  logic [2:0] cur_segs;
  logic [7:0] ch_low [3];
  logic [7:0] ch_high[3];

  logic [7:0] ln_tab [256];
  logic [7:0] pow_tab[256];
  pix_out_t   want_q[$];
  int         err_cnt = 0;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  const int unsigned slope_tab[3][5] = '{'{63, 128, 64, 0, 0}, '{31, 96, 96, 32, 0},
                                         '{15, 64, 96, 64, 16}};
  const int unsigned base_tab[3][5]  = '{'{0, 63, 191, 0, 0}, '{0, 31, 127, 191, 0},
                                         '{0, 15, 79, 175, 239}};

  function automatic logic [7:0] clamp8(longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned q40_mul(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[103:40];
  endfunction

  // log and exp tables, fixed-point as in rcs_pkg
  task automatic fill_tables();
    longint unsigned acc, term, s, odd, m, v, pw, b;
    acc = 0;
    ln_tab[0] = 8'd0;
    for (int k = 1; k < 256; k++) begin
      m = 2 * k + 1;
      term = (64'd1 << 56) / m;
      s = 0;
      odd = 1;
      while (term != 0) begin
        s += term / odd;
        term /= m * m;
        odd += 2;
      end
      acc += 2 * s;
      v = ((acc >> 24) * 46 + (64'd1 << 31)) >> 32;
      ln_tab[k] = clamp8(v);
    end
    for (int p = 0; p < 256; p++) begin
      pw = 64'd1 << 40;
      b  = 64'd4389378616 << 8;
      for (int i = 0; i < 8; i++) begin
        if (p[i]) pw = q40_mul(pw, b);
        b = q40_mul(b, b);
      end
      pow_tab[p] = clamp8((pw + (64'd1 << 39)) >> 40);
    end
  endtask

  function automatic logic [7:0] stretch_chan(logic [7:0] p, logic [7:0] lo, logic [7:0] hi);
    longint unsigned sc, r, d, j, row;
    case (cur_mode)
      ModeLinear: begin
        if (hi <= lo || p <= lo) return 8'd0;
        return clamp8(round_div(longint'(p - lo) * 255, hi - lo));
      end
      ModePiece: begin
        if (hi <= lo || p < lo) return 8'd0;
        sc  = (cur_segs == 3) ? 3 : (cur_segs == 4) ? 4 : 5;
        row = sc - 3;
        r   = hi - lo + 1;
        d   = p - lo;
        for (j = 1; j < sc && sc * (d + 1) > j * r; j++) ;
        if (j == 1) begin
          // a pixel at the low bound in the first segment gives 0
          if (d == 0) return 8'd0;
          return clamp8(round_div(slope_tab[row][0] * d * sc, r - sc));
        end
        return clamp8(base_tab[row][j-1] +
                      round_div(slope_tab[row][j-1] * (sc * (d + 1) - (j - 1) * r), r));
      end
      ModeLog: return ln_tab[p];
      default: return pow_tab[p];
    endcase
  endfunction

  function automatic pix_out_t predict_pixel(pix_in_t px);
    pix_out_t o;
    o.red_out   = stretch_chan(px.red_in, ch_low[0], ch_high[0]);
    o.green_out = stretch_chan(px.green_in, ch_low[1], ch_high[1]);
    o.blue_out  = stretch_chan(px.blue_in, ch_low[2], ch_high[2]);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // register write; valid is left high, the caller lowers it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgMode:      cur_mode = mode_e'(val[1:0]);
      CfgSegs:      cur_segs = val[2:0];
      CfgRedLow:    ch_low[0] = val;
      CfgRedHigh:   ch_high[0] = val;
      CfgGreenLow:  ch_low[1] = val;
      CfgGreenHigh: ch_high[1] = val;
      CfgBlueLow:   ch_low[2] = val;
      CfgBlueHigh:  ch_high[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // one pixel transaction; valid is left high, the caller lowers it
  task automatic send_pixel(pix_in_t px, bit typed, pix_out_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    want_q.push_back(typed ? want : predict_pixel(px));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_pix(int c);
    case ($urandom_range(0, 5))
      0: return 8'(ch_low[c] + $urandom_range(0, 4) - 2);
      1: return 8'(ch_high[c] + $urandom_range(0, 4) - 2);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // result side: random stall bursts, no new ones when idling is off
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (want_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        pix_out_t w;
        w = want_q.pop_front();
        if (out_data_o.red_out !== w.red_out)
          report_mismatch($sformatf("red %0d want %0d", out_data_o.red_out, w.red_out));
        if (out_data_o.green_out !== w.green_out)
          report_mismatch($sformatf("green %0d want %0d", out_data_o.green_out, w.green_out));
        if (out_data_o.blue_out !== w.blue_out)
          report_mismatch($sformatf("blue %0d want %0d", out_data_o.blue_out, w.blue_out));
      end
    end
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  typedef struct {
    bit                 is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [7:0]         val;
    pix_in_t            px;
    bit                 typed;
    pix_out_t           want;
  } row_t;

  row_t dir_q[$];

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    return '{1'b1, idx, val, '0, 1'b0, '0};
  endfunction

  function automatic row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return '{1'b0, '0, '0, {r, g, b}, 1'b0, '0};
  endfunction

  function automatic row_t typed_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] wr, logic [7:0] wg, logic [7:0] wb);
    return '{1'b0, '0, '0, {r, g, b}, 1'b1, {wr, wg, wb}};
  endfunction

  initial begin
    pix_in_t px;
    bit      was_cfg;
    fill_tables();
    cur_mode = ModeLinear;
    cur_segs = 3'd3;
    for (int c = 0; c < 3; c++) begin
      ch_low[c]  = 8'd0;
      ch_high[c] = 8'd255;
    end

    // directed table: reset identity, bound cases, every mode and segment count
    dir_q = '{
      typed_row(0, 255, 128, 0, 255, 128), typed_row(1, 254, 127, 1, 254, 127),
      cfg_row(CfgRedLow, 200), cfg_row(CfgRedHigh, 100), cfg_row(CfgGreenLow, 50),
      cfg_row(CfgGreenHigh, 50), cfg_row(CfgBlueLow, 10), cfg_row(CfgBlueHigh, 20),
      typed_row(255, 255, 5, 0, 0, 0), typed_row(150, 50, 30, 0, 0, 255),
      pix_row(201, 51, 15),
      cfg_row(CfgMode, {6'd0, ModePiece}), cfg_row(CfgSegs, 3),
      cfg_row(CfgRedLow, 0), cfg_row(CfgRedHigh, 255), cfg_row(CfgGreenLow, 10),
      cfg_row(CfgGreenHigh, 200), cfg_row(CfgBlueLow, 0), cfg_row(CfgBlueHigh, 2),
      pix_row(0, 10, 0), pix_row(255, 200, 1), pix_row(64, 100, 2), pix_row(128, 9, 255),
      cfg_row(CfgSegs, 4), pix_row(31, 100, 3), pix_row(200, 150, 128),
      cfg_row(CfgSegs, 5), pix_row(15, 60, 1), pix_row(240, 199, 2),
      cfg_row(CfgSegs, 0), pix_row(100, 11, 0), cfg_row(CfgSegs, 7), pix_row(170, 180, 1),
      cfg_row(CfgMode, {6'd0, ModeLog}), typed_row(0, 255, 1, 0, 255, 32), pix_row(1, 2, 128),
      cfg_row(CfgMode, {6'b101010, ModeExp}), typed_row(0, 0, 0, 1, 1, 1),
      pix_row(255, 128, 77),
      cfg_row(CfgUnused, 8'hA5), pix_row(254, 127, 3)
    };
    // the typed log row above: 46*ln(256) and 46*ln(2) read off directly
    dir_q[34].want = {8'd0, 8'd255, 8'd32};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    was_cfg = 1'b1;
    foreach (dir_q[i]) begin
      if (dir_q[i].is_cfg) begin
        if (!was_cfg) wait_drained();
        write_reg(dir_q[i].idx, dir_q[i].val);
      end else begin
        if (was_cfg) cfg_valid_i <= 1'b0;
        send_pixel(dir_q[i].px, dir_q[i].typed, dir_q[i].want);
      end
      was_cfg = dir_q[i].is_cfg;
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      idle_on = (ph < Phases - 1);
      if (ph < 4) write_reg(CfgMode, {6'($urandom), mode_e'(ph)});
      else        write_reg(CfgMode, 8'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(CfgSegs, 8'($urandom));
      else write_reg(CfgSegs, 8'($urandom_range(3, 5)));
      for (int c = 0; c < 3; c++) begin
        write_reg(CfgIdxW'(CfgRedLow + 2 * c), pick_bound());
        write_reg(CfgIdxW'(CfgRedHigh + 2 * c), pick_bound());
        if ($urandom_range(0, 2) != 0 && ch_high[c] < ch_low[c]) begin
          write_reg(CfgIdxW'(CfgRedLow + 2 * c), ch_high[c]);
          write_reg(CfgIdxW'(CfgRedHigh + 2 * c), ch_low[c] == ch_high[c] ? 8'd255 : ch_low[c]);
        end
      end
      if (ph == 1) begin
        write_reg(CfgRedLow, 8'd0);
        write_reg(CfgRedHigh, 8'd255);
      end
      if ($urandom_range(0, 2) == 0) write_reg(CfgUnused, 8'($urandom));
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < PerPhase; n++) begin
        // let the pipeline empty once with the sender holding off
        if (ph == 2 && n == PerPhase / 2) begin
          in_valid_i <= 1'b0;
          while (want_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        px.red_in   = pick_pix(0);
        px.green_in = pick_pix(1);
        px.blue_in  = pick_pix(2);
        send_pixel(px, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (want_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 8) @(posedge clk_i);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
